### rtl/pip_pkg.sv
// Shared types and constants of the point-in-polygon test block.
package pip_pkg;

  // Configuration port
  localparam int PADDR_W   = 3;
  localparam int PDATA_W   = 32;
  localparam int REG_IDX_W = PADDR_W - 2;
  localparam logic [REG_IDX_W-1:0] REG_SIDE_COUNT = 1'b0;

  // Register and field widths
  localparam int SIDE_COUNT_W = 4;
  localparam logic [SIDE_COUNT_W-1:0] SIDE_COUNT_RST = 4'd8;
  localparam int VIDX_W = 3;

  // Command codes
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_TEST = 1'b1;

  // Multiply sequence: two products, four half-width partials each
  localparam int MAC_STEP_W = 3;
  localparam logic [MAC_STEP_W-1:0] MAC_LAST = 3'd7;

  // Partial product weight, in half-word steps
  localparam logic [1:0] SH_0 = 2'd0;
  localparam logic [1:0] SH_1 = 2'd1;
  localparam logic [1:0] SH_2 = 2'd2;

  typedef struct packed {
    logic       clear;  // zero the accumulator
    logic       issue;  // start a partial product this cycle
    logic       sub;    // subtract the weighted partial instead of adding
    logic [1:0] shift;  // weight code of the partial
  } mac_ctrl_t;

endpackage

### rtl/pip_if.sv
// Valid/ready channel interfaces for vertex/test words and result words.
interface pip_in_if #(
  parameter int COORD_WIDTH = 32
) ();
  logic                              valid;
  logic                              ready;
  logic                              cmd;
  logic [pip_pkg::VIDX_W-1:0]        vertex_index;
  logic signed [COORD_WIDTH-1:0]     coord_x;
  logic signed [COORD_WIDTH-1:0]     coord_y;

  modport source (output valid, output cmd, output vertex_index, output coord_x,
                  output coord_y, input ready);
  modport sink (input valid, input cmd, input vertex_index, input coord_x,
                input coord_y, output ready);
endinterface

interface pip_out_if ();
  logic valid;
  logic ready;
  logic inside_res;

  modport source (output valid, output inside_res, input ready);
  modport sink (input valid, input inside_res, output ready);
endinterface

### rtl/pip_ram.sv
// Generic single-write, single-read RAM with registered read data.
module pip_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, hold data when not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/pip_mac.sv
// Shared half-width multiplier with weighted signed accumulator.
module pip_mac #(
  parameter int HALF_W = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  pip_pkg::mac_ctrl_t        ctrl,
  input  logic [HALF_W-1:0]         a,
  input  logic [HALF_W-1:0]         b,
  output logic signed [4*HALF_W+1:0] acc
);

  localparam int AW = 4 * HALF_W + 2;

  logic [2*HALF_W-1:0] prod;
  logic                prod_valid;
  logic                prod_sub;
  logic [1:0]          prod_shift;
  logic signed [AW-1:0] term;

  // Multiply stage: register the partial product and its tag
  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
    end else begin
      prod_valid <= ctrl.issue;
    end
  end

  always_ff @(posedge clk) begin
    prod       <= a * b;
    prod_sub   <= ctrl.sub;
    prod_shift <= ctrl.shift;
  end

  // Weight the partial by its half-word position
  always_comb begin
    case (prod_shift)
      pip_pkg::SH_0: term = $signed(AW'(prod));
      pip_pkg::SH_1: term = $signed(AW'(prod) << HALF_W);
      pip_pkg::SH_2: term = $signed(AW'(prod) << (2 * HALF_W));
      default:       term = '0;
    endcase
  end

  // Accumulate stage
  always_ff @(posedge clk) begin
    if (ctrl.clear) begin
      acc <= '0;
    end else if (prod_valid) begin
      acc <= prod_sub ? acc - term : acc + term;
    end
  end

endmodule

### rtl/point_in_polygon_test.sv
// Point-in-polygon test by the even-odd rule. A load word writes one vertex
// into the vertex RAM. A test word walks the n vertices in use one edge per
// cycle while no edge needs multiplying; an edge that straddles the test y
// with an end at or left of the test x is resolved exactly by cross
// multiplication, which runs as eight half-width partial products through one
// shared multiplier and stalls the walk through the multiply, drain and compare
// states. A test holds the block through its walk and in the finish state while
// the previous result still waits to be taken; the input is not ready meanwhile.
// The result sits in an output register, so loads are taken while it waits.
module point_in_polygon_test #(
  parameter int MAX_SIDES   = 8,
  parameter int COORD_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  pip_in_if.sink                        item,
  pip_out_if.source                     result,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [pip_pkg::PADDR_W-1:0]   paddr,
  input  logic [pip_pkg::PDATA_W-1:0]   pwdata,
  output logic [pip_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready
);

  localparam int CW = COORD_WIDTH;
  localparam int H  = (CW + 1) / 2;
  localparam int AW = 4 * H + 2;
  localparam int IW = $clog2(MAX_SIDES);
  localparam int NW = $clog2(MAX_SIDES + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_PREV = 3'd1;
  localparam logic [2:0] S_EDGE = 3'd2;
  localparam logic [2:0] S_MUL  = 3'd3;
  localparam logic [2:0] S_WAIT = 3'd4;
  localparam logic [2:0] S_CMP  = 3'd5;
  localparam logic [2:0] S_FIN  = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;

  logic [pip_pkg::SIDE_COUNT_W-1:0] side_count;
  logic [NW-1:0] n_eff;
  logic [NW-1:0] n_use;
  logic [IW-1:0] idx;
  logic [pip_pkg::MAC_STEP_W-1:0] step;

  logic signed [CW-1:0] px, py;
  logic signed [CW-1:0] prev_x, prev_y;
  logic signed [CW-1:0] cur_x, cur_y;
  logic signed [CW-1:0] xi, yi;

  logic [CW-1:0] dyi_mag, dxji_mag, dxi_mag, dy_mag;
  logic          dyi_neg, dxji_neg, dxi_neg, dy_neg;
  logic signed [CW:0] d_dyi, d_dxji, d_dxi, d_dy;

  logic          odd;
  logic          res_valid;
  logic          res_val;

  logic          accept;
  logic          cfg_wr;
  logic          ram_we;
  logic          ram_re;
  logic [IW-1:0] ram_raddr;
  logic [2*CW-1:0] ram_wdata;
  logic [2*CW-1:0] ram_rdata;

  logic          straddle;
  logic          edge_hit;
  logic          edge_last;
  logic          fin_fire;
  logic          left;

  logic [2*H-1:0] op_a_ext, op_b_ext;
  logic [H-1:0]   op_a, op_b;
  pip_pkg::mac_ctrl_t mac_ctrl;
  logic signed [AW-1:0] acc;

  // Handshakes
  assign accept      = item.valid && item.ready;
  assign item.ready  = (state == S_IDLE);
  assign result.valid      = res_valid;
  assign result.inside_res = res_val;
  assign fin_fire    = (state == S_FIN) && (!res_valid || result.ready);

  // Configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = (paddr[pip_pkg::PADDR_W-1:2] == pip_pkg::REG_SIDE_COUNT)
                  ? pip_pkg::PDATA_W'(side_count) : '0;

  // Saturate the vertex count to the store depth
  always_comb begin
    if (32'(side_count) > 32'(MAX_SIDES)) begin
      n_eff = NW'(MAX_SIDES);
    end else begin
      n_eff = NW'(side_count);
    end
  end

  // Vertex store: x in the upper half, y in the lower half
  assign ram_we    = accept && (item.cmd == pip_pkg::CMD_LOAD) &&
                     (32'(item.vertex_index) < 32'(MAX_SIDES));
  assign ram_wdata = {CW'(item.coord_x), CW'(item.coord_y)};

  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = '0;
    case (state)
      S_IDLE: begin
        ram_re    = accept && (item.cmd == pip_pkg::CMD_TEST);
        ram_raddr = IW'(n_eff - NW'(1));
      end
      S_PREV: begin
        ram_re    = 1'b1;
        ram_raddr = '0;
      end
      S_EDGE: begin
        ram_re    = !edge_last;
        ram_raddr = idx + IW'(1);
      end
      default: begin
        ram_re    = 1'b0;
        ram_raddr = '0;
      end
    endcase
  end

  pip_ram #(
    .WIDTH (2 * CW),
    .DEPTH (MAX_SIDES)
  ) u_vertex_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (IW'(item.vertex_index)),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Edge from vertex i (just read) to the previous vertex j
  assign xi = $signed(ram_rdata[2*CW-1:CW]);
  assign yi = $signed(ram_rdata[CW-1:0]);

  assign straddle  = ((yi < py) && (prev_y >= py)) || ((prev_y < py) && (yi >= py));
  assign edge_hit  = straddle && ((xi <= px) || (prev_x <= px));
  assign edge_last = (NW'(idx) == n_use - NW'(1));

  // Differences for the cross multiplication
  assign d_dyi  = (CW+1)'(py)     - (CW+1)'(yi);
  assign d_dxji = (CW+1)'(prev_x) - (CW+1)'(xi);
  assign d_dxi  = (CW+1)'(px)     - (CW+1)'(xi);
  assign d_dy   = (CW+1)'(prev_y) - (CW+1)'(yi);

  // Sequencer
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept && (item.cmd == pip_pkg::CMD_TEST)) begin
          state_next = (n_eff == '0) ? S_FIN : S_PREV;
        end
      end
      S_PREV: state_next = S_EDGE;
      S_EDGE: begin
        if (edge_hit) begin
          state_next = S_MUL;
        end else if (edge_last) begin
          state_next = S_FIN;
        end
      end
      S_MUL: begin
        if (step == pip_pkg::MAC_LAST) begin
          state_next = S_WAIT;
        end
      end
      S_WAIT: state_next = S_CMP;
      S_CMP:  state_next = edge_last ? S_FIN : S_EDGE;
      S_FIN: begin
        if (fin_fire) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      res_valid  <= 1'b0;
      side_count <= pip_pkg::SIDE_COUNT_RST;
    end else begin
      state <= state_next;
      if (cfg_wr && (paddr[pip_pkg::PADDR_W-1:2] == pip_pkg::REG_SIDE_COUNT)) begin
        side_count <= pwdata[pip_pkg::SIDE_COUNT_W-1:0];
      end
      if (fin_fire) begin
        res_valid <= 1'b1;
      end else if (result.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // Working registers of one test
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (accept && (item.cmd == pip_pkg::CMD_TEST)) begin
          px     <= item.coord_x;
          py     <= item.coord_y;
          n_use  <= n_eff;
          odd    <= 1'b0;
          idx    <= '0;
        end
      end
      S_PREV: begin
        prev_x <= $signed(ram_rdata[2*CW-1:CW]);
        prev_y <= $signed(ram_rdata[CW-1:0]);
      end
      S_EDGE: begin
        if (edge_hit) begin
          cur_x    <= xi;
          cur_y    <= yi;
          dyi_neg  <= d_dyi[CW];
          dxji_neg <= d_dxji[CW];
          dxi_neg  <= d_dxi[CW];
          dy_neg   <= d_dy[CW];
          dyi_mag  <= d_dyi[CW]  ? CW'(-d_dyi)  : CW'(d_dyi);
          dxji_mag <= d_dxji[CW] ? CW'(-d_dxji) : CW'(d_dxji);
          dxi_mag  <= d_dxi[CW]  ? CW'(-d_dxi)  : CW'(d_dxi);
          dy_mag   <= d_dy[CW]   ? CW'(-d_dy)   : CW'(d_dy);
          step     <= '0;
        end else begin
          prev_x <= xi;
          prev_y <= yi;
          idx    <= idx + IW'(1);
        end
      end
      S_MUL: begin
        step <= step + pip_pkg::MAC_STEP_W'(1);
      end
      S_CMP: begin
        if (left) begin
          odd <= ~odd;
        end
        prev_x <= cur_x;
        prev_y <= cur_y;
        idx    <= idx + IW'(1);
      end
      S_FIN: begin
        if (fin_fire) begin
          res_val <= odd;
        end
      end
      default: begin
      end
    endcase
  end

  // Partial product operands: first (y - yi)*(xj - xi), then (x - xi)*dy
  assign op_a_ext = step[2] ? (2*H)'(dxi_mag) : (2*H)'(dyi_mag);
  assign op_b_ext = step[2] ? (2*H)'(dy_mag)  : (2*H)'(dxji_mag);
  assign op_a     = step[1] ? op_a_ext[2*H-1:H] : op_a_ext[H-1:0];
  assign op_b     = step[0] ? op_b_ext[2*H-1:H] : op_b_ext[H-1:0];

  // Accumulate lhs minus rhs
  always_comb begin
    mac_ctrl.clear = (state == S_EDGE) && edge_hit;
    mac_ctrl.issue = (state == S_MUL);
    mac_ctrl.sub   = step[2] ? !(dxi_neg ^ dy_neg) : (dyi_neg ^ dxji_neg);
    case (step[1:0])
      2'b00:   mac_ctrl.shift = pip_pkg::SH_0;
      2'b11:   mac_ctrl.shift = pip_pkg::SH_2;
      default: mac_ctrl.shift = pip_pkg::SH_1;
    endcase
  end

  pip_mac #(
    .HALF_W (H)
  ) u_mac (
    .clk  (clk),
    .rst  (rst),
    .ctrl (mac_ctrl),
    .a    (op_a),
    .b    (op_b),
    .acc  (acc)
  );

  // Crossing lies left of the point: sense follows the sign of the edge height
  assign left = dy_neg ? (!acc[AW-1] && (acc != '0)) : acc[AW-1];

  // Checks
  a_result_from_fin: assert property (@(posedge clk) disable iff (rst)
    $rose(result.valid) |-> ($past(state) == S_FIN))
    else $error("result raised outside the finish state");

  a_test_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    (accept && (item.cmd == pip_pkg::CMD_TEST)) |=> (state != S_IDLE))
    else $error("test word accepted without starting a walk");

  a_index_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_EDGE) |-> (NW'(idx) < n_use))
    else $error("edge index past the vertex count");

  a_cmp_after_drain: assert property (@(posedge clk) disable iff (rst)
    (state == S_CMP) |-> ($past(state) == S_WAIT))
    else $error("compare taken before the accumulator drained");

endmodule

### bench/point_in_polygon_test_tb.sv
// Self-checking bench for the point-in-polygon block: random polygons, exact parity prediction.
module point_in_polygon_test_tb;

  localparam int MAX_SIDES     = 8;
  localparam int COORD_W       = 32;
  localparam int IDLE_LIMIT    = 4000;
  localparam int SETTLE_CYCLES = 100;
  localparam int ONE           = 65536;
  localparam int PHASE_WORDS   = 52;
  localparam logic signed [COORD_W-1:0] C_MAX = 32'sh7fff_ffff;
  localparam logic signed [COORD_W-1:0] C_MIN = 32'sh8000_0000;
  localparam logic [pip_pkg::PADDR_W-1:0] ADDR_SIDE_COUNT = {pip_pkg::REG_SIDE_COUNT, 2'b00};
  localparam logic [pip_pkg::PADDR_W-1:0] ADDR_UNUSED     = {~pip_pkg::REG_SIDE_COUNT, 2'b00};

  typedef struct packed {
    logic                       cmd;
    logic [pip_pkg::VIDX_W-1:0] slot;
    logic [COORD_W-1:0]         x;
    logic [COORD_W-1:0]         y;
  } pip_word_t;

  logic                         clk;
  logic                         rst;
  logic                         psel;
  logic                         penable;
  logic                         pwrite;
  logic [pip_pkg::PADDR_W-1:0]  paddr;
  logic [pip_pkg::PDATA_W-1:0]  pwdata;
  logic [pip_pkg::PDATA_W-1:0]  prdata;
  logic                         pready;

  pip_in_if #(.COORD_WIDTH(COORD_W)) item_if ();
  pip_out_if result_if ();

  point_in_polygon_test #(
    .MAX_SIDES  (MAX_SIDES),
    .COORD_WIDTH(COORD_W)
  ) dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_if),
    .result (result_if),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  // Words waiting to be sent and inside flags waiting to come back
  pip_word_t pending_words[$];
  logic      expected_inside[$];

  // Predicted block state
  logic [pip_pkg::SIDE_COUNT_W-1:0] side_count_model;
  logic signed [COORD_W-1:0] vx_model[MAX_SIDES];
  logic signed [COORD_W-1:0] vy_model[MAX_SIDES];

  // Polygon as the generator last queued it, used to aim test points
  logic signed [COORD_W-1:0] gen_vx[MAX_SIDES];
  logic signed [COORD_W-1:0] gen_vy[MAX_SIDES];

  int unsigned count_plan[13] = '{3, 8, 0, 1, 2, 15, 9, 5, 6, 7, 4, 12, 8};
  int          scale_plan[7]  = '{3, 6, 12, 17, 24, 31, 32};

  int        errors;
  int        queued_words;
  int        taken_words;
  int        loads_taken;
  int        tests_taken;
  int        insides_predicted;
  int        results_checked;
  int        settings_used;
  int        gap_left;
  int        stall_left;
  int        quiet_cycles;
  bit        calm;
  logic      predicted;
  logic      want_inside;
  pip_word_t next_word;

  // Clock
  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Mostly short gaps, now and then a long one
  function automatic int pick_idle();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Signed value spread over the low bits of the word
  function automatic logic signed [COORD_W-1:0] rand_coord(input int bits);
    logic signed [COORD_W-1:0] v;
    v = $urandom;
    return v >>> (COORD_W - bits);
  endfunction

  // Even-odd parity over the edges in use, crossing resolved exactly
  function automatic logic crossing_parity(input logic signed [COORD_W-1:0] px,
                                           input logic signed [COORD_W-1:0] py);
    int                 n;
    int                 i;
    int                 j;
    logic               parity;
    logic               left;
    longint signed      xi, yi, xj, yj;
    logic signed [127:0] d_ty, d_ex, d_tx, d_ey, lhs, rhs;
    n = (side_count_model > MAX_SIDES) ? MAX_SIDES : int'(side_count_model);
    parity = 1'b0;
    if (n == 0) return 1'b0;
    j = n - 1;
    for (i = 0; i < n; i++) begin
      xi = vx_model[i];
      yi = vy_model[i];
      xj = vx_model[j];
      yj = vy_model[j];
      if (((yi < py && yj >= py) || (yj < py && yi >= py)) && (xi <= px || xj <= px)) begin
        d_ty = longint'(py) - yi;
        d_ex = xj - xi;
        d_tx = longint'(px) - xi;
        d_ey = yj - yi;
        lhs  = d_ty * d_ex;
        rhs  = d_tx * d_ey;
        left = (d_ey > 0) ? (lhs < rhs) : (lhs > rhs);
        parity ^= left;
      end
      j = i;
    end
    return parity;
  endfunction

  task automatic report_mismatch(input string what);
    if (errors < 40) $display("[%0t] mismatch: %s", $time, what);
    errors++;
  endtask

  // Input driver: hold the word until taken, then idle or advance
  always @(posedge clk) begin
    if (rst) begin
      item_if.valid        <= 1'b0;
      item_if.cmd          <= pip_pkg::CMD_LOAD;
      item_if.vertex_index <= '0;
      item_if.coord_x      <= '0;
      item_if.coord_y      <= '0;
      gap_left = 0;
    end else begin
      if (item_if.valid && item_if.ready) begin
        taken_words++;
        if (item_if.cmd == pip_pkg::CMD_LOAD) begin
          vx_model[item_if.vertex_index] = item_if.coord_x;
          vy_model[item_if.vertex_index] = item_if.coord_y;
          loads_taken++;
        end else begin
          predicted = crossing_parity(item_if.coord_x, item_if.coord_y);
          expected_inside = {expected_inside, predicted};
          tests_taken++;
          if (predicted) insides_predicted++;
        end
      end
      if (!(item_if.valid && !item_if.ready)) begin
        if (gap_left > 0) begin
          gap_left--;
          item_if.valid <= 1'b0;
        end else if (pending_words.size() != 0) begin
          next_word = pending_words.pop_front();
          item_if.valid        <= 1'b1;
          item_if.cmd          <= next_word.cmd;
          item_if.vertex_index <= next_word.slot;
          item_if.coord_x      <= next_word.x;
          item_if.coord_y      <= next_word.y;
          gap_left = calm ? 0 : pick_idle();
        end else begin
          item_if.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: check against the oldest prediction, stall at random
  always @(posedge clk) begin
    if (rst) begin
      result_if.ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (result_if.valid && result_if.ready) begin
        if (expected_inside.size() == 0) begin
          report_mismatch("result word with no test outstanding");
        end else begin
          want_inside = expected_inside.pop_front();
          results_checked++;
          if (result_if.inside_res !== want_inside)
            report_mismatch($sformatf("test %0d: inside_res %b, expected %b",
                                      results_checked, result_if.inside_res, want_inside));
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        result_if.ready <= 1'b0;
      end else begin
        result_if.ready <= 1'b1;
        if (!calm && $urandom_range(0, 3) == 0) stall_left = pick_idle();
      end
    end
  end

  // Watchdog on cycles in which nothing moves
  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles = 0;
    end else if ((item_if.valid && item_if.ready) || (result_if.valid && result_if.ready) ||
                 (psel && penable && pready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("watchdog: no word moved for %0d cycles", IDLE_LIMIT);
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  task automatic push_load(input int unsigned slot, input logic signed [COORD_W-1:0] x,
                           input logic signed [COORD_W-1:0] y);
    pip_word_t w;
    w.cmd  = pip_pkg::CMD_LOAD;
    w.slot = slot[pip_pkg::VIDX_W-1:0];
    w.x    = x;
    w.y    = y;
    gen_vx[slot] = x;
    gen_vy[slot] = y;
    pending_words = {pending_words, w};
    queued_words++;
  endtask

  task automatic push_test(input logic signed [COORD_W-1:0] x,
                           input logic signed [COORD_W-1:0] y);
    pip_word_t w;
    w.cmd  = pip_pkg::CMD_TEST;
    w.slot = pip_pkg::VIDX_W'($urandom_range(0, MAX_SIDES - 1));
    w.x    = x;
    w.y    = y;
    pending_words = {pending_words, w};
    queued_words++;
  endtask

  // Reload every slot; some flat edges and repeated vertices on purpose
  task automatic queue_polygon(input int bits);
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    int r;
    for (int k = 0; k < MAX_SIDES; k++) begin
      r = $urandom_range(0, 99);
      x = rand_coord(bits);
      y = rand_coord(bits);
      if (k > 0 && r < 10) begin
        x = gen_vx[k-1];
        y = gen_vy[k-1];
      end else if (k > 0 && r < 30) begin
        y = gen_vy[k-1];
      end
      push_load(k, x, y);
    end
  endtask

  // Test point: free, on a vertex level, mixed corner, edge midpoint, on a vertex, full range
  task automatic queue_test(input int bits);
    int a;
    int b;
    int r;
    logic signed [COORD_W:0]   sum_x;
    logic signed [COORD_W:0]   sum_y;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    a = $urandom_range(0, MAX_SIDES - 1);
    b = (a == 0) ? MAX_SIDES - 1 : a - 1;
    r = $urandom_range(0, 99);
    x = rand_coord(bits);
    y = rand_coord(bits);
    if (r < 35) begin
      // free point at the polygon's scale
    end else if (r < 55) begin
      y = gen_vy[a];
    end else if (r < 70) begin
      x = gen_vx[a];
      y = gen_vy[b];
    end else if (r < 85) begin
      sum_x = {gen_vx[a][COORD_W-1], gen_vx[a]} + {gen_vx[b][COORD_W-1], gen_vx[b]};
      sum_y = {gen_vy[a][COORD_W-1], gen_vy[a]} + {gen_vy[b][COORD_W-1], gen_vy[b]};
      x = sum_x[COORD_W:1];
      y = sum_y[COORD_W:1];
    end else if (r < 92) begin
      x = gen_vx[a];
      y = gen_vy[a];
    end else begin
      x = $urandom;
      y = $urandom;
    end
    push_test(x, y);
  endtask

  // One phase of random traffic: mostly tests on a fresh polygon, some vertex churn
  task automatic queue_phase(input int words, input int bits);
    int r;
    queue_polygon(bits);
    repeat (words) begin
      r = $urandom_range(0, 99);
      if (r < 3) begin
        queue_polygon(bits);
      end else if (r < 22) begin
        push_load($urandom_range(0, MAX_SIDES - 1),
                  rand_coord(($urandom_range(0, 3) == 0) ? COORD_W : bits), rand_coord(bits));
      end else begin
        queue_test(bits);
      end
    end
  endtask

  // Drain: every word taken, every result back, then let a trailing load finish
  task automatic wait_idle();
    do @(posedge clk);
    while (taken_words != queued_words || expected_inside.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apb_write(input logic [pip_pkg::PADDR_W-1:0] addr,
                           input logic [pip_pkg::PDATA_W-1:0] data);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk);
    while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr[pip_pkg::PADDR_W-1:2] == pip_pkg::REG_SIDE_COUNT)
      side_count_model = data[pip_pkg::SIDE_COUNT_W-1:0];
  endtask

  task automatic check_side_count_readback();
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= ADDR_SIDE_COUNT;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk);
    while (!pready);
    if (prdata[pip_pkg::SIDE_COUNT_W-1:0] !== side_count_model)
      report_mismatch($sformatf("side_count read %0d, expected %0d",
                                prdata[pip_pkg::SIDE_COUNT_W-1:0], side_count_model));
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Stimulus and end of run
  initial begin
    logic [pip_pkg::PDATA_W-1:0] data;
    rst                  <= 1'b1;
    psel                 <= 1'b0;
    penable              <= 1'b0;
    pwrite               <= 1'b0;
    paddr                <= '0;
    pwdata               <= '0;
    side_count_model = pip_pkg::SIDE_COUNT_RST;
    for (int k = 0; k < MAX_SIDES; k++) begin
      vx_model[k] = '0;
      vy_model[k] = '0;
      gen_vx[k]   = '0;
      gen_vy[k]   = '0;
    end
    errors = 0;
    queued_words = 0;
    taken_words = 0;
    loads_taken = 0;
    tests_taken = 0;
    insides_predicted = 0;
    results_checked = 0;
    settings_used = 1;
    calm = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Octagon at the reset side count: centre, outside, on a vertex, vertex level, extremes
    push_load(0, 10 * ONE, 0);
    push_load(1, 7 * ONE, 7 * ONE);
    push_load(2, 0, 10 * ONE);
    push_load(3, -7 * ONE, 7 * ONE);
    push_load(4, -10 * ONE, 0);
    push_load(5, -7 * ONE, -7 * ONE);
    push_load(6, 0, -10 * ONE);
    push_load(7, 7 * ONE, -7 * ONE);
    push_test(0, 0);
    push_test(20 * ONE, 0);
    push_test(10 * ONE, 0);
    push_test(0, 7 * ONE);
    push_test(C_MAX, C_MAX);
    push_test(C_MIN, C_MIN);
    push_test(C_MIN, 0);
    wait_idle();
    check_side_count_readback();

    // Full-range square on four sides: widest differences and products
    apb_write(ADDR_SIDE_COUNT, 32'd4);
    settings_used++;
    push_load(0, C_MIN, C_MIN);
    push_load(1, C_MAX, C_MIN);
    push_load(2, C_MAX, C_MAX);
    push_load(3, C_MIN, C_MAX);
    push_test(0, 0);
    push_test(C_MAX, 0);
    push_test(C_MIN, 0);
    push_test(0, C_MAX);
    push_test(C_MAX, C_MAX);
    wait_idle();

    // Random phases over side counts, the degenerate and saturating ones among them
    foreach (count_plan[p]) begin
      if (p == 3) apb_write(ADDR_UNUSED, $urandom);
      data = $urandom;
      data[pip_pkg::SIDE_COUNT_W-1:0] = count_plan[p][pip_pkg::SIDE_COUNT_W-1:0];
      apb_write(ADDR_SIDE_COUNT, data);
      check_side_count_readback();
      settings_used++;
      calm = (p % 4 == 2);
      queue_phase(PHASE_WORDS, scale_plan[$urandom_range(0, 6)]);
      wait_idle();
    end

    $display("Sent %0d vertex loads and %0d point tests over %0d side-count settings.",
             loads_taken, tests_taken, settings_used);
    $display("Checked %0d inside flags (%0d predicted inside), %0d mismatches.",
             results_checked, insides_predicted, errors);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
